// ===== hw/rtl/shell_command_lexer_top_assert.svh =====
// Assertion macros for the shell command lexer.
`ifndef SHELL_COMMAND_LEXER_TOP_ASSERT_SVH
`define SHELL_COMMAND_LEXER_TOP_ASSERT_SVH
`ifndef SYNTH
`define SLC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SLC_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define SLC_ASSERT(lbl, clk, rst, prop, msg)
`define SLC_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// ===== hw/rtl/slc_pkg.sv =====
// Shared types and constants of the shell command lexer.
`default_nettype none
package slc_pkg;

  typedef enum logic [1:0] {
    MODE_BETWEEN = 2'd0,
    MODE_WORD    = 2'd1,
    MODE_QUOTED  = 2'd2,
    MODE_DROP    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    EV_BYTE = 3'd0,
    EV_END  = 3'd1,
    EV_LONG = 3'd2,
    EV_MANY = 3'd3,
    EV_LINE = 3'd4
  } event_t;

  localparam logic [2:0] KIND_WORD  = 3'd0;
  localparam logic [2:0] KIND_LT    = 3'd1;
  localparam logic [2:0] KIND_GT    = 3'd2;
  localparam logic [2:0] KIND_PIPE  = 3'd3;
  localparam logic [2:0] KIND_AMP   = 3'd4;
  localparam logic [2:0] KIND_SEMI  = 3'd5;
  localparam logic [2:0] KIND_OPEN  = 3'd6;
  localparam logic [2:0] KIND_CLOSE = 3'd7;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_PIPE  = 8'h7C;

  localparam logic [7:0] RESET_MAX_TOKEN_CHARS = 8'd254;
  localparam logic [7:0] RESET_MAX_TOKENS      = 8'd100;

  // register index is paddr[2]
  localparam logic REG_MAX_TOKEN_CHARS = 1'b0;
  localparam logic REG_MAX_TOKENS      = 1'b1;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int MAX_RES    = 3;

  typedef struct packed {
    logic [7:0] max_token_chars;
    logic [7:0] max_tokens;
  } slc_cfg_t;

  typedef struct packed {
    logic       last_of_item;
    logic [7:0] token_number;
    logic [2:0] token_kind;
    logic [7:0] token_byte;
    event_t     event_res;
  } slc_res_t;

  typedef struct packed {
    logic [1:0]         n;
    slc_res_t [2:0]     res;
  } slc_push_t;

endpackage
`default_nettype wire

// ===== hw/rtl/slc_regs.sv =====
// Configuration registers behind the APB-style port.
`default_nettype none
module slc_regs (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output slc_pkg::slc_cfg_t     cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_token_chars <= slc_pkg::RESET_MAX_TOKEN_CHARS;
      cfg.max_tokens      <= slc_pkg::RESET_MAX_TOKENS;
    end else if (wr) begin
      unique case (paddr[2])
        slc_pkg::REG_MAX_TOKEN_CHARS: cfg.max_token_chars <= pwdata[7:0];
        slc_pkg::REG_MAX_TOKENS:      cfg.max_tokens      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      slc_pkg::REG_MAX_TOKEN_CHARS: prdata = {24'd0, cfg.max_token_chars};
      slc_pkg::REG_MAX_TOKENS:      prdata = {24'd0, cfg.max_tokens};
      default:                      prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/slc_core.sv =====
// Input register and single-pass lexer step producing up to three results.
`default_nettype none
module slc_core #(
  parameter int TOKEN_LEN_LIMIT   = 255,
  parameter int TOKEN_COUNT_LIMIT = 128
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire slc_pkg::slc_cfg_t cfg,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,
  input  wire logic              room,
  output slc_pkg::slc_push_t     push
);

  logic                 in_vld;
  logic [7:0]           in_byte;
  slc_pkg::mode_t       mode, mode_next;
  logic [7:0]           len, len_next;
  logic [7:0]           cnt, cnt_next;
  logic                 take;
  logic [7:0]           char_lim, count_lim;
  logic [2:0]           kind;
  logic                 blank, done;
  logic                 do_end, do_start, do_append, do_line;
  slc_pkg::slc_res_t [2:0] res;
  logic [1:0]           n;

  function automatic slc_pkg::slc_res_t mk_res(slc_pkg::event_t e, logic [7:0] b,
                                                logic [2:0] k, logic [7:0] num);
    slc_pkg::slc_res_t r;
    r.event_res    = e;
    r.token_byte   = b;
    r.token_kind   = k;
    r.token_number = num;
    r.last_of_item = 1'b0;
    return r;
  endfunction

  assign take     = in_vld && room;
  assign s_tready = !in_vld || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= slc_pkg::MODE_BETWEEN;
      len  <= 8'd0;
      cnt  <= 8'd0;
    end else if (take) begin
      mode <= mode_next;
      len  <= len_next;
      cnt  <= cnt_next;
    end
  end

  // clamp the register values to the usable range
  always_comb begin
    char_lim = cfg.max_token_chars;
    if (char_lim == 8'd0) char_lim = 8'd1;
    if (char_lim > 8'(TOKEN_LEN_LIMIT - 1)) char_lim = 8'(TOKEN_LEN_LIMIT - 1);
    count_lim = cfg.max_tokens;
    if (count_lim == 8'd0) count_lim = 8'd1;
    if (count_lim > 8'(TOKEN_COUNT_LIMIT)) count_lim = 8'(TOKEN_COUNT_LIMIT);
  end

  always_comb begin
    case (in_byte)
      slc_pkg::CH_LT:    kind = slc_pkg::KIND_LT;
      slc_pkg::CH_GT:    kind = slc_pkg::KIND_GT;
      slc_pkg::CH_PIPE:  kind = slc_pkg::KIND_PIPE;
      slc_pkg::CH_AMP:   kind = slc_pkg::KIND_AMP;
      slc_pkg::CH_SEMI:  kind = slc_pkg::KIND_SEMI;
      slc_pkg::CH_OPEN:  kind = slc_pkg::KIND_OPEN;
      slc_pkg::CH_CLOSE: kind = slc_pkg::KIND_CLOSE;
      default:           kind = slc_pkg::KIND_WORD;
    endcase
  end

  assign blank = (in_byte == slc_pkg::CH_SPACE) || (in_byte == slc_pkg::CH_TAB);
  assign done  = (in_byte == slc_pkg::CH_NUL);

  // pick the actions for this byte
  always_comb begin
    do_end    = 1'b0;
    do_start  = 1'b0;
    do_append = 1'b0;
    do_line   = 1'b0;
    unique case (mode)
      slc_pkg::MODE_BETWEEN: begin
        if (done) do_line = 1'b1;
        else if (!blank) do_start = 1'b1;
      end
      slc_pkg::MODE_WORD: begin
        if (done) begin
          do_end  = 1'b1;
          do_line = 1'b1;
        end else if (blank) begin
          do_end = 1'b1;
        end else if (kind != slc_pkg::KIND_WORD) begin
          do_end   = 1'b1;
          do_start = 1'b1;
        end else begin
          do_append = 1'b1;
        end
      end
      slc_pkg::MODE_QUOTED: begin
        if (done) begin
          do_end  = 1'b1;
          do_line = 1'b1;
        end else if (in_byte == slc_pkg::CH_QUOTE) begin
          do_end = 1'b1;
        end else begin
          do_append = 1'b1;
        end
      end
      slc_pkg::MODE_DROP: begin
        if (done) do_line = 1'b1;
      end
      default: ;
    endcase
  end

  // run the actions in order, collecting results
  always_comb begin
    logic app;
    app       = do_append;
    mode_next = mode;
    len_next  = len;
    cnt_next  = cnt;
    res       = '0;
    n         = 2'd0;
    if (do_end) begin
      res[n]    = mk_res(slc_pkg::EV_END, 8'd0, slc_pkg::KIND_WORD, cnt_next);
      n         = n + 2'd1;
      cnt_next  = cnt_next + 8'd1;
      len_next  = 8'd0;
      mode_next = slc_pkg::MODE_BETWEEN;
    end
    if (do_start) begin
      if (cnt_next >= count_lim) begin
        res[n]    = mk_res(slc_pkg::EV_MANY, 8'd0, slc_pkg::KIND_WORD, cnt_next);
        n         = n + 2'd1;
        mode_next = slc_pkg::MODE_DROP;
      end else if (kind != slc_pkg::KIND_WORD) begin
        res[n]    = mk_res(slc_pkg::EV_BYTE, in_byte, kind, cnt_next);
        n         = n + 2'd1;
        res[n]    = mk_res(slc_pkg::EV_END, 8'd0, kind, cnt_next);
        n         = n + 2'd1;
        cnt_next  = cnt_next + 8'd1;
        len_next  = 8'd0;
        mode_next = slc_pkg::MODE_BETWEEN;
      end else if (in_byte == slc_pkg::CH_QUOTE) begin
        mode_next = slc_pkg::MODE_QUOTED;
        len_next  = 8'd0;
      end else begin
        mode_next = slc_pkg::MODE_WORD;
        len_next  = 8'd0;
        app       = 1'b1;
      end
    end
    if (app) begin
      if ({1'b0, len_next} + 9'd1 > {1'b0, char_lim}) begin
        res[n]    = mk_res(slc_pkg::EV_LONG, 8'd0, slc_pkg::KIND_WORD, cnt_next);
        n         = n + 2'd1;
        mode_next = slc_pkg::MODE_DROP;
      end else begin
        len_next = len_next + 8'd1;
        res[n]   = mk_res(slc_pkg::EV_BYTE, in_byte, slc_pkg::KIND_WORD, cnt_next);
        n        = n + 2'd1;
      end
    end
    if (do_line) begin
      res[n]    = mk_res(slc_pkg::EV_LINE, 8'd0, slc_pkg::KIND_WORD, cnt_next);
      n         = n + 2'd1;
      mode_next = slc_pkg::MODE_BETWEEN;
      len_next  = 8'd0;
      cnt_next  = 8'd0;
    end
    if (n != 2'd0) res[n - 2'd1].last_of_item = 1'b1;
  end

  assign push.n   = take ? n : 2'd0;
  assign push.res = res;

endmodule
`default_nettype wire

// ===== hw/rtl/slc_fifo.sv =====
// Result queue: takes up to three results a cycle, hands out one while m_tready is high.
`default_nettype none
module slc_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire slc_pkg::slc_push_t push,
  output logic                    room,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output slc_pkg::slc_res_t       head
);

  slc_pkg::slc_res_t                    mem [slc_pkg::FIFO_DEPTH];
  logic [slc_pkg::FIFO_AW-1:0]          wp, rp;
  logic [slc_pkg::FIFO_AW:0]            count;
  logic                                 pop;

  assign m_tvalid = (count != '0);
  assign pop      = m_tvalid && m_tready;
  // space for a full burst of results
  assign room     = count <= (slc_pkg::FIFO_AW + 1)'(slc_pkg::FIFO_DEPTH - slc_pkg::MAX_RES);
  assign head     = mem[rp];

  always_ff @(posedge clk) begin
    for (int i = 0; i < slc_pkg::MAX_RES; i++) begin
      if (2'(i) < push.n) begin
        mem[wp + slc_pkg::FIFO_AW'(i)] <= push.res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + slc_pkg::FIFO_AW'(push.n);
      rp    <= rp + slc_pkg::FIFO_AW'(pop);
      count <= count + (slc_pkg::FIFO_AW + 1)'(push.n)
                     - (slc_pkg::FIFO_AW + 1)'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/shell_command_lexer_top.sv =====
// The first result of a request reaches the output through the input register, then the
// result queue, whose head drives the output.
// Throughput: one byte per cycle while each byte gives at most one result and m_tready is
// high; a byte that gives two or three results needs that many reads from the single read
// port of the 8-entry result queue, which stalls input once fewer than three entries are free.
// Reset (rst, synchronous): lexer between tokens, counts zero, queue empty, registers 254/100.
`default_nettype none
`include "shell_command_lexer_top_assert.svh"
module shell_command_lexer_top #(
  parameter int TOKEN_LEN_LIMIT   = 255,
  parameter int TOKEN_COUNT_LIMIT = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [2:0] event_res, [10:3] token_byte,
                                      // [13:11] token_kind, [21:14] token_number, [23:22] zero
  output logic             m_tlast,   // last_of_item
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  slc_pkg::slc_cfg_t  cfg;
  slc_pkg::slc_push_t push;
  slc_pkg::slc_res_t  head;
  logic               room;

  slc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  slc_core #(
    .TOKEN_LEN_LIMIT   (TOKEN_LEN_LIMIT),
    .TOKEN_COUNT_LIMIT (TOKEN_COUNT_LIMIT)
  ) u_core (
    .clk, .rst, .cfg, .s_tvalid, .s_tready, .s_tdata, .room, .push
  );

  slc_fifo u_fifo (
    .clk, .rst, .push, .room, .m_tvalid, .m_tready, .head
  );

  assign m_tdata = {2'b00, head.token_number, head.token_kind, head.token_byte,
                    head.event_res};
  assign m_tlast = head.last_of_item;

  `SLC_ASSERT(a_line_last, clk, rst, (m_tvalid && head.event_res == slc_pkg::EV_LINE) |-> m_tlast, "line done not last result")
  `SLC_ASSERT(a_byte_zero, clk, rst, (m_tvalid && head.event_res != slc_pkg::EV_BYTE) |-> (head.token_byte == 8'd0), "token byte set on non-byte result")
  `SLC_NEVER(a_stall_empty, clk, rst, !s_tready && !m_tvalid, "input stalled with empty queue")

endmodule
`default_nettype wire
